// File: design/swpm_pkg.sv
// ----------------------------------------------------------------------------
// swpm_pkg
// Shared types, codes and constants of the square-wave period meter.
// ----------------------------------------------------------------------------
package swpm_pkg;

    // default width of the free-running timer
    localparam int TIMER_BITS_DEF = 16;

    // field and register widths
    localparam int ELAPSED_W = 27;
    localparam int OVF_W     = 12;
    localparam int PERIODS_W = 16;
    localparam int SYNC_W    = 10;
    localparam int MEAS_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int PHASE_W   = 3;

    // saturation value of the elapsed count
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // register reset values
    localparam logic [PERIODS_W-1:0] PERIODS_RST = 16'd100;
    localparam logic [SYNC_W-1:0]    SYNC_RST    = 10'd5;
    localparam logic [MEAS_W-1:0]    MEAS_RST    = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS    = 2'd2;

    // measurement phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SYNC_LOW  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SYNC_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MEAS_LOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MEAS_HIGH = 3'd4;

    // one registered input beat
    typedef struct packed {
        logic pin_level;
        logic start_req;
    } t_item;

    // one result from the phase logic
    typedef struct packed {
        logic                 valid;
        logic [ELAPSED_W-1:0] elapsed_ticks;
        logic                 no_signal;
    } t_result;

endpackage

// File: design/swpm_in_reg.sv
// ----------------------------------------------------------------------------
// swpm_in_reg
// Input register: holds one accepted tick until the phase logic takes it.
// ----------------------------------------------------------------------------
module swpm_in_reg
    import swpm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  logic  i_pin_level,
    input  logic  i_start_req,
    input  logic  i_adv,
    output logic  o_item_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // hold off only when a beat sits here and cannot move on
    assign o_in_stall = r_valid && !i_adv;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.pin_level <= i_pin_level;
            r_item.start_req <= i_start_req;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// File: design/swpm_core.sv
// ----------------------------------------------------------------------------
// swpm_core
// Timer, phase sequencer, overflow counting and elapsed-tick arithmetic.
// ----------------------------------------------------------------------------
module swpm_core
    import swpm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_adv,
    input  t_item                i_item,
    output t_result              o_res
);

    localparam int SUM_W = OVF_W + TIMER_BITS;
    localparam int EXT_W = (SUM_W > ELAPSED_W) ? SUM_W : ELAPSED_W;

    logic [PERIODS_W-1:0]  r_periods;
    logic [SYNC_W-1:0]     r_sync_lim;
    logic [MEAS_W-1:0]     r_meas_lim;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [PHASE_W-1:0]    r_phase, n_phase;
    logic [OVF_W-1:0]      r_ovf, n_ovf;
    logic [TIMER_BITS-1:0] r_stamp, n_stamp;
    logic [PERIODS_W-1:0]  r_left, n_left;

    logic                  wrap;
    logic [OVF_W-1:0]      ovf_inc;
    logic [OVF_W-1:0]      ovf_meas;
    logic [PERIODS_W-1:0]  left_dec;
    logic [SUM_W-1:0]      now_sum;
    logic [SUM_W-1:0]      stamp_ext;
    logic [SUM_W-1:0]      diff;
    logic [EXT_W-1:0]      diff_ext;
    logic [ELAPSED_W-1:0]  elapsed;
    logic                  hit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods  <= PERIODS_RST;
            r_sync_lim <= SYNC_RST;
            r_meas_lim <= MEAS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIODS: r_periods  <= i_cfg_data[PERIODS_W-1:0];
                CFG_SYNC:    r_sync_lim <= i_cfg_data[SYNC_W-1:0];
                CFG_MEAS:    r_meas_lim <= i_cfg_data[MEAS_W-1:0];
                default:     ;
            endcase
        end
    end

    // timer step and overflow counting
    assign n_timer  = r_timer + 1'b1;
    assign wrap     = (n_timer == '0);
    assign ovf_inc  = r_ovf + 1'b1;
    assign ovf_meas = wrap ? ovf_inc : r_ovf;
    assign left_dec = r_left - 1'b1;

    // elapsed ticks since capture, clamped at zero and saturated
    assign now_sum   = (SUM_W'(ovf_meas) << TIMER_BITS) + SUM_W'(n_timer);
    assign stamp_ext = SUM_W'(r_stamp);
    assign diff      = (now_sum >= stamp_ext) ? (now_sum - stamp_ext) : '0;
    assign diff_ext  = EXT_W'(diff);
    assign elapsed   = (diff_ext > EXT_W'(ELAPSED_MAX)) ? ELAPSED_MAX
                                                        : diff_ext[ELAPSED_W-1:0];

    // level condition of the sync waits
    assign hit = (r_phase == PH_SYNC_LOW) ? !i_item.pin_level : i_item.pin_level;

    // phase sequencer
    always_comb begin
        n_phase = r_phase;
        n_ovf   = r_ovf;
        n_stamp = r_stamp;
        n_left  = r_left;
        o_res   = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_phase = PH_SYNC_LOW;
                    n_ovf   = '0;
                end
            end
            PH_SYNC_LOW, PH_SYNC_HIGH: begin
                if (hit) begin
                    n_ovf = '0;
                    if (r_phase == PH_SYNC_LOW) begin
                        n_phase = PH_SYNC_HIGH;
                    end else begin
                        n_stamp = n_timer;
                        n_left  = r_periods;
                        if (r_periods == '0) begin
                            o_res.valid = 1'b1;
                            n_phase     = PH_IDLE;
                        end else begin
                            n_phase = PH_MEAS_LOW;
                        end
                    end
                end else if (wrap) begin
                    n_ovf = ovf_inc;
                    if (ovf_inc > OVF_W'(r_sync_lim)) begin
                        o_res.valid     = 1'b1;
                        o_res.no_signal = 1'b1;
                        n_phase         = PH_IDLE;
                    end
                end
            end
            PH_MEAS_LOW, PH_MEAS_HIGH: begin
                n_ovf = ovf_meas;
                if (wrap && (ovf_inc > OVF_W'(r_meas_lim))) begin
                    // abort wins over completion
                    o_res.valid     = 1'b1;
                    o_res.no_signal = 1'b1;
                    n_phase         = PH_IDLE;
                end else if (r_phase == PH_MEAS_LOW) begin
                    if (!i_item.pin_level) begin
                        n_phase = PH_MEAS_HIGH;
                    end
                end else if (i_item.pin_level) begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        o_res.valid         = 1'b1;
                        o_res.elapsed_ticks = elapsed;
                        n_phase             = PH_IDLE;
                    end else begin
                        n_phase = PH_MEAS_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // state registers, one step per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_phase <= PH_IDLE;
            r_ovf   <= '0;
            r_stamp <= '0;
            r_left  <= '0;
        end else if (i_adv) begin
            r_timer <= n_timer;
            r_phase <= n_phase;
            r_ovf   <= n_ovf;
            r_stamp <= n_stamp;
            r_left  <= n_left;
        end
    end

endmodule

// File: design/swpm_out_reg.sv
// ----------------------------------------------------------------------------
// swpm_out_reg
// Result register: presents one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module swpm_out_reg
    import swpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  t_result              i_res,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ELAPSED_W-1:0] o_elapsed_ticks,
    output logic                 o_no_signal
);

    logic                 r_valid;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_nosig;

    // room for a new result this cycle
    assign o_free = !r_valid || !i_out_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_adv && i_res.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_adv && i_res.valid) begin
            r_elapsed <= i_res.elapsed_ticks;
            r_nosig   <= i_res.no_signal;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_elapsed_ticks = r_elapsed;
    assign o_no_signal     = r_nosig;

endmodule

// File: design/square_wave_period_meter_top.sv
// ----------------------------------------------------------------------------
// square_wave_period_meter_top
// Square-wave period meter with overflow timeouts.
// ----------------------------------------------------------------------------
// Each input beat is one tick of the sampled square wave. The meter takes one
// beat per clock cycle while the output register is not stalled: a beat is
// registered in the input register, then the phase logic runs on it when it
// steps and writes any result into the output register. Only a stalled,
// full output register holds the input side back. A start request in idle
// arms the sync waits (level low, then high, each aborted after more than
// sync_limit timer wraps); the rising level captures the timer and the meter
// then counts periods_to_measure low-to-high cycles, aborting after more than
// measure_limit wraps. A finished measurement reports the elapsed ticks
// (saturated to 27 bits), an abort reports no_signal with zero ticks.
// Register writes act on the beats that follow them, so make them only while
// no beat is in flight; periods_to_measure is latched at capture.
// ----------------------------------------------------------------------------
module square_wave_period_meter_top
    import swpm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_pin_level,
    input  logic                 i_start_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ELAPSED_W-1:0] o_elapsed_ticks,
    output logic                 o_no_signal
);

    logic    item_valid;
    t_item   item;
    t_result res;
    logic    out_free;
    logic    adv;

    // the phase logic steps when a beat is held and the result slot is open
    assign adv = item_valid && out_free;

    swpm_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pin_level  (i_pin_level),
        .i_start_req  (i_start_req),
        .i_adv        (adv),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    swpm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (adv),
        .i_item      (item),
        .o_res       (res)
    );

    swpm_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_res           (res),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_elapsed_ticks (o_elapsed_ticks),
        .o_no_signal     (o_no_signal)
    );

    // an aborted measurement carries no tick count
    a_nosig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_signal |-> o_elapsed_ticks == '0)
        else $error("no-signal result with nonzero ticks");

    // input back-pressure only comes from a stalled, full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output slot is open");

    // a new result beat follows a step of the phase logic
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(adv))
        else $error("result appeared without a processed beat");

endmodule
